@@ rtl/psl_pkg.sv @@
// Shared types and constants for the prefix-sum lower-bound lookup.
// No dependencies; imported by the controller, the datapath and the top level.
package psl_pkg;

  localparam int DATA_W      = 32;  // operand and prefix sum width
  localparam int POS_W       = 11;  // result position width
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic append;       // store a new running sum (or mark overflow)
    logic start;        // load search bounds and target
    logic probe;        // read the table at the midpoint
    logic step;         // narrow the bounds on the read data
    logic load_result;  // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;  // bounds have met
    logic out_free;     // output register can take a result this cycle
  } status_t;

endpackage

@@ rtl/psl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module psl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/psl_ctrl.sv @@
// Sequencer for appends and binary-search queries.
// Depends on psl_pkg for the command and status structs and opcodes.
module psl_ctrl
  import psl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    opcode,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = ST_PROBE;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status.search_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.step   = 1'b1;
        state_next = ST_PROBE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/psl_dp.sv @@
// Datapath: running total, entry count, prefix RAM, search bounds, output register.
// Depends on psl_pkg and psl_ram.
module psl_dp
  import psl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [DATA_W-1:0]      operand,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  logic [CW-1:0]     entry_count;
  logic [DATA_W-1:0] running_total;
  logic              overflow_seen;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [DATA_W-1:0] target;
  logic [POS_W-1:0]  position;
  logic              not_found;
  logic              table_full;

  logic [CW-1:0]     mid;
  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] sum_sat;
  logic              full;
  logic [DATA_W-1:0] rd_data;
  logic [PW-1:0]     pos_ext;

  assign mid      = lo + ((hi - lo) >> 1);
  assign sum_wide = {1'b0, running_total} + {1'b0, operand};
  assign sum_sat  = sum_wide[DATA_W] ? {DATA_W{1'b1}} : sum_wide[DATA_W-1:0];
  assign full     = (entry_count == CW'(TABLE_DEPTH));
  assign pos_ext  = PW'(lo) + PW'(1);

  psl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.append && !full),
    .wr_addr (entry_count[AW-1:0]),
    .wr_data (sum_sat),
    .rd_en   (cmd.probe),
    .rd_addr (mid[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      running_total <= '0;
      overflow_seen <= 1'b0;
      lo            <= '0;
      hi            <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.append) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          entry_count   <= entry_count + CW'(1);
          running_total <= sum_sat;
        end
      end
      if (cmd.start) begin
        lo     <= '0;
        hi     <= entry_count;
        target <= operand;
      end
      if (cmd.step) begin
        if (rd_data < target) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      if (cmd.load_result) begin
        m_tvalid   <= 1'b1;
        position   <= pos_ext[POS_W-1:0];
        not_found  <= (lo == entry_count);
        table_full <= overflow_seen;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign status.search_done = (lo == hi);
  assign status.out_free    = !m_tvalid || m_tready;

  assign m_tdata = {{(OUT_TDATA_W - POS_W){1'b0}}, position};
  assign m_tuser = {table_full, not_found};

`ifndef SYNTHESIS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst) lo <= hi)
    else $error("search bounds crossed");
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending beat");
  a_hi_within_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> hi <= entry_count)
    else $error("search upper bound past stored entries");
`endif

endmodule

@@ rtl/prefix_sum_lower_bound_lookup.sv @@
// Top level of the prefix-sum lower-bound lookup.
// Depends on psl_pkg, psl_ctrl, psl_dp (which holds psl_ram).
//
// Channel  Dir  Beat contents
// -------  ---  -----------------------------------------------------------
// s_*      in   tuser[0] opcode (0 append, 1 query); tdata[31:0] operand_value
// m_*      out  tdata[10:0] position; tuser[0] not_found, tuser[1] table_full
//
// Sequence: an append keeps the controller in ST_IDLE, so s_tready stays high.
// A query runs p binary-search probes, p being at most ceil(log2(count+1)),
// so at most 11 for 1024 entries; each probe is a registered RAM read in
// ST_PROBE then a compare in ST_CMP; ST_DONE then waits for the output register.
// Reset (rst, synchronous) empties the table, clears the total and the
// full flag; RAM contents are not cleared and are read only once written.
// Stalls: a result waits in the output register while appends and a new
// query go on; a finished search holds until that register is free.
module prefix_sum_lower_bound_lookup
  import psl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] operand_value
  input  logic                   s_tuser,   // [0] opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [10:0] position, [15:11] zero
  output logic [OUT_TUSER_W-1:0] m_tuser    // [0] not_found, [1] table_full
);

  cmd_t    cmd;
  status_t status;

  // sequencer: accepts beats only between queries
  psl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, arithmetic and output register
  psl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .operand  (s_tdata[DATA_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ bench/prefix_sum_lower_bound_lookup_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for prefix_sum_lower_bound_lookup: appends and queries on the stream
// ports, answers predicted by a scoreboard class. Needs psl_pkg and the lookup RTL.
module prefix_sum_lower_bound_lookup_tb;
  import psl_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int ITEMS       = 2000;   // random beats, split over three idle patterns
  localparam int HOLD_AT     = 250;    // answers seen before the long output hold
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;     // longer than the longest query, with margin
  localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             not_found;
    logic             table_full;
  } answer_t;

  // Scoreboard: keeps its own prefix table and queues the answer each query must get.
  class lookup_checker;
    bit [DATA_W-1:0] sums [DEPTH];
    int unsigned     count;
    bit [DATA_W-1:0] total;
    bit              overflow;
    answer_t         answers_q[$];
    int              errors;
    int              results_seen;
    int              appends;
    int              dropped;
    int              clipped;
    int              queries;

    // index of the first stored sum not below target, count if none
    function int unsigned first_sum_not_below(logic [DATA_W-1:0] target);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (sums[mid] < target) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_input(logic op, logic [DATA_W-1:0] val);
      logic [DATA_W:0] wide;
      answer_t         ans;
      int unsigned     idx;
      if (op == OP_APPEND) begin
        appends++;
        if (count >= DEPTH) begin
          overflow = 1'b1;
          dropped++;
        end else begin
          wide = {1'b0, total} + {1'b0, val};
          if (wide[DATA_W]) begin
            total = '1;   // saturate
            clipped++;
          end else begin
            total = wide[DATA_W-1:0];
          end
          sums[count] = total;
          count++;
        end
      end else begin
        queries++;
        idx            = first_sum_not_below(val);
        ans.position   = POS_W'(idx + 1);
        ans.not_found  = (idx == count);
        ans.table_full = overflow;
        answers_q.insert(answers_q.size(), ans);
      end
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("MISMATCH answer %0d: %s got 0x%0h, want 0x%0h", results_seen, what, got, want);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      answer_t want;
      results_seen++;
      if (answers_q.size() == 0) begin
        report_mismatch("beat with no query waiting", tdata, 0);
        return;
      end
      want = answers_q.pop_front();
      if (tdata[POS_W-1:0] !== want.position)
        report_mismatch("position", tdata[POS_W-1:0], want.position);
      if (tdata[OUT_TDATA_W-1:POS_W] !== '0)
        report_mismatch("tdata padding", tdata[OUT_TDATA_W-1:POS_W], 0);
      if (tuser[0] !== want.not_found)
        report_mismatch("not_found", tuser[0], want.not_found);
      if (tuser[1] !== want.table_full)
        report_mismatch("table_full", tuser[1], want.table_full);
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] operand_value
  logic                   s_tuser;   // [0] opcode
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [10:0] position, [15:11] zero
  logic [OUT_TUSER_W-1:0] m_tuser;   // [0] not_found, [1] table_full

  lookup_checker sb;
  int            snd_idle_pct = 33;
  int            rcv_idle_pct = 60;
  bit            hold_done    = 1'b0;

  prefix_sum_lower_bound_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive one beat: optional idle cycles first, then hold valid until the block takes it.
  // Inputs move on the falling edge; s_tready is sampled on the rising edge.
  task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = val;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, val);
  endtask

  // Sender pause: drop valid and wait until every query has been answered.
  task automatic wait_for_answers();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.answers_q.size() != 0) @(posedge clk);
  endtask

  // Random beat. Appends stay small so the table fills long before the total saturates;
  // near the top of the table they go full range, so saturation and the drop path are hit.
  // Query targets mostly land on, just above or just below a stored sum.
  task automatic pick_item(output logic op, output logic [DATA_W-1:0] val);
    bit          near_full;
    int unsigned pick;
    near_full = (sb.count + 24 >= DEPTH);
    op = ($urandom_range(0, 99) < (near_full ? 45 : 55)) ? OP_APPEND : OP_QUERY;
    if (op == OP_APPEND) begin
      if ($urandom_range(0, 7) == 0) val = near_full ? '1 : '0;
      else val = near_full ? $urandom : $urandom_range(1, 1 << 21);
    end else begin
      pick = (sb.count == 0) ? 0 : $urandom_range(0, sb.count - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: val = sb.sums[pick];
        4:          val = sb.sums[pick] + 1;
        5:          val = sb.sums[pick] - 1;
        6, 7:       val = $urandom_range(0, sb.total);
        8:          val = $urandom;
        default:    val = $urandom_range(0, 1) ? '1 : '0;
      endcase
    end
  endtask

  // Output side: random ready, one long hold once HOLD_AT answers are in so the result
  // register stays full and the block must stall its input while beats keep coming.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sb.results_seen >= HOLD_AT) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      m_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // Watchdog: ends the run if neither side moves a beat for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d answers outstanding",
             STALL_LIMIT, sb.answers_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic            op;
    logic [DATA_W-1:0] val;
    int              n;
    int              full_queries;
    sb       = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_APPEND;
    full_queries = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, repeated sums, exact hits, neighbors, target past the end.
    send_item(OP_QUERY,  32'd0);
    send_item(OP_QUERY,  32'hFFFF_FFFF);
    send_item(OP_APPEND, 32'd0);
    send_item(OP_APPEND, 32'd0);         // two equal sums: lower bound picks the first
    send_item(OP_APPEND, 32'd7);
    send_item(OP_APPEND, 32'd1);         // table is 0, 0, 7, 8
    send_item(OP_QUERY,  32'd0);
    send_item(OP_QUERY,  32'd1);
    send_item(OP_QUERY,  32'd6);
    send_item(OP_QUERY,  32'd7);
    send_item(OP_QUERY,  32'd8);
    send_item(OP_QUERY,  32'd9);         // past every sum
    send_item(OP_QUERY,  32'hFFFF_FFFF);
    send_item(OP_APPEND, 32'd100);
    send_item(OP_APPEND, 32'h0001_0000);
    send_item(OP_QUERY,  32'd50);
    send_item(OP_QUERY,  32'd108);
    send_item(OP_QUERY,  32'h0001_006C);
    send_item(OP_QUERY,  32'h0001_006D);

    // Random: sender 33 / receiver 60 idle, then swapped, then both always ready.
    // The last pattern runs on until the table has overflowed and been queried a while.
    for (int ph = 0; ph < 3; ph++) begin
      wait_for_answers();
      snd_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 60 : 0;
      rcv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 33 : 0;
      n = 0;
      while (n < ITEMS / 3 || (ph == 2 && (!sb.overflow || full_queries < 40))) begin
        pick_item(op, val);
        send_item(op, val);
        if (op == OP_QUERY && sb.overflow) full_queries++;
        n++;
      end
    end

    wait_for_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.answers_q.size() != 0)
      sb.report_mismatch("answers never delivered", sb.answers_q.size(), 0);

    $display("Covered %0d appends (%0d dropped on a full table, %0d clipped by saturation)",
             sb.appends, sb.dropped, sb.clipped);
    $display("and %0d queries; %0d answers checked under three idle patterns, %0d mismatches.",
             sb.queries, sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
